[design/circle_rect_collide_reflect_macros.svh]
`ifndef CIRCLE_RECT_COLLIDE_REFLECT_MACROS_SVH
`define CIRCLE_RECT_COLLIDE_REFLECT_MACROS_SVH

// cons must hold in the same cycle as ante, checked out of reset
`define CRC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("collision check failed");

// cons must follow ante after the delay given by lat
`define CRC_ASSERT_LAT(lbl, ante, lat, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##lat (cons)) \
    else $error("collision latency check failed");

`endif

[design/crc_pkg.sv]
`default_nettype none

package crc_pkg;

  // coordinate width after doubling, with headroom for differences
  localparam int CW = 21;
  // doubled radius, doubled edge length
  localparam int RW = 13;
  localparam int LW = 14;
  localparam int VW = 16;
  // corner offset width, valid while offset is within the radius
  localparam int DW = 15;
  localparam int SQW = 29;
  localparam int SW = 30;
  localparam int DOTW = 32;
  // normalization search
  localparam int PW = 64;
  localparam int NORM_STEPS = 15;
  localparam int MAG_W = 15;
  localparam int R_SHIFT = 30;
  localparam int NW = 16;
  localparam int NCORNER = 4;
  localparam int CIDX_W = $clog2(NCORNER);
  localparam logic signed [NW-1:0] ONE_Q14 = 16'sd16384;

  typedef enum logic [2:0] {
    CT_NONE   = 3'd0,
    CT_LEFT   = 3'd1,
    CT_BOTTOM = 3'd2,
    CT_RIGHT  = 3'd3,
    CT_TOP    = 3'd4,
    CT_CORNER = 3'd5
  } contact_t;

  typedef struct packed {
    logic     hit;
    contact_t contact;
    logic     sx;
    logic     sy;
    logic     szero;
  } res_tag_t;

endpackage

`default_nettype wire

[design/circle_rect_collide_reflect.sv]
// Circle versus axis-aligned rectangle collision with reflection normal.
// A query is taken on every clock where start is high; busy is always low,
// so one query per cycle is sustained. Each query gives exactly one result,
// shown for one cycle with done high, after four stages of geometry (doubled
// coordinates and edges, edge tests and corner offsets, products, corner
// pick), a 15-stage normalization pipeline that settles one bit of the Q1.14
// corner normal per stage, and the output register. The receiver cannot
// stall, so results must be captured on the cycle done is high.
`default_nettype none
`include "circle_rect_collide_reflect_macros.svh"

module circle_rect_collide_reflect import crc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [15:0]   ball_x,
  input  logic signed [15:0]   ball_y,
  input  logic [11:0]          radius,
  input  logic signed [15:0]   vel_x,
  input  logic signed [15:0]   vel_y,
  input  logic signed [15:0]   rect_x,
  input  logic signed [15:0]   rect_y,
  input  logic [12:0]          rect_w,
  input  logic [12:0]          rect_h,
  output logic                 done,
  output logic                 hit,
  output logic [2:0]           contact,
  output logic signed [NW-1:0] normal_x,
  output logic signed [NW-1:0] normal_y
);

  localparam int LATENCY = 4 + NORM_STEPS + 1;

  function automatic logic [CW-1:0] mag_of(input logic signed [CW-1:0] v);
    mag_of = v[CW-1] ? CW'(-v) : CW'(v);
  endfunction

  function automatic logic touch(input logic signed [CW-1:0] along,
                                 input logic [LW-1:0] len,
                                 input logic signed [CW-1:0] perp,
                                 input logic [RW-1:0] rad);
    touch = (len != '0) && !along[CW-1] && (along <= $signed(CW'(len)))
            && (mag_of(perp) <= CW'(rad));
  endfunction

  assign busy = 1'b0;

  // stage 1: doubled coordinates and rectangle edges
  logic signed [CW-1:0] a_cx, a_cy, a_rx, a_ry, a_w, a_h;
  assign a_cx = CW'($signed({ball_x, 1'b0}));
  assign a_cy = CW'($signed({ball_y, 1'b0}));
  assign a_rx = CW'($signed({rect_x, 1'b0}));
  assign a_ry = CW'($signed({rect_y, 1'b0}));
  assign a_w  = $signed(CW'(rect_w));
  assign a_h  = $signed(CW'(rect_h));

  logic                 s1_valid;
  logic signed [CW-1:0] s1_cx, s1_cy, s1_left, s1_right, s1_bottom, s1_top;
  logic [LW-1:0]        s1_wlen, s1_hlen;
  logic [RW-1:0]        s1_rad;
  logic signed [VW-1:0] s1_vx, s1_vy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
    end
    s1_cx     <= a_cx;
    s1_cy     <= a_cy;
    s1_left   <= a_rx - a_w;
    s1_right  <= a_rx + a_w;
    s1_bottom <= a_ry - a_h;
    s1_top    <= a_ry + a_h;
    s1_wlen   <= {rect_w, 1'b0};
    s1_hlen   <= {rect_h, 1'b0};
    s1_rad    <= {radius, 1'b0};
    s1_vx     <= vel_x;
    s1_vy     <= vel_y;
  end

  // stage 2: edge tests in priority order, corner offsets
  logic     t_left, t_bottom, t_right, t_top;
  logic     b_decided, b_hit;
  contact_t b_contact;
  logic signed [CW-1:0] b_dx [NCORNER];
  logic signed [CW-1:0] b_dy [NCORNER];
  logic [NCORNER-1:0]   b_inr;

  assign t_left   = touch(s1_top - s1_cy, s1_hlen, s1_cx - s1_left, s1_rad);
  assign t_bottom = touch(s1_cx - s1_left, s1_wlen, s1_cy - s1_bottom, s1_rad);
  assign t_right  = touch(s1_cy - s1_bottom, s1_hlen, s1_cx - s1_right, s1_rad);
  assign t_top    = touch(s1_right - s1_cx, s1_wlen, s1_cy - s1_top, s1_rad);

  always_comb begin
    b_decided = 1'b1;
    b_hit     = 1'b0;
    b_contact = CT_NONE;
    priority if (t_left) begin
      if (s1_vx > 16'sd0) begin
        b_hit     = 1'b1;
        b_contact = CT_LEFT;
      end
    end else if (t_bottom) begin
      if (s1_vy > 16'sd0) begin
        b_hit     = 1'b1;
        b_contact = CT_BOTTOM;
      end
    end else if (t_right) begin
      if (s1_vx < 16'sd0) begin
        b_hit     = 1'b1;
        b_contact = CT_RIGHT;
      end
    end else if (t_top) begin
      if (s1_vy < 16'sd0) begin
        b_hit     = 1'b1;
        b_contact = CT_TOP;
      end
    end else begin
      b_decided = 1'b0;
    end
  end

  // corners: left-top, left-bottom, right-bottom, right-top
  always_comb begin
    for (int c = 0; c < NCORNER; c++) begin
      b_dx[c]  = s1_cx - ((c < 2) ? s1_left : s1_right);
      b_dy[c]  = s1_cy - ((c == 1 || c == 2) ? s1_bottom : s1_top);
      b_inr[c] = (mag_of(b_dx[c]) <= CW'(s1_rad)) && (mag_of(b_dy[c]) <= CW'(s1_rad));
    end
  end

  logic                 s2_valid, s2_decided, s2_hit;
  contact_t             s2_contact;
  logic signed [DW-1:0] s2_dx [NCORNER];
  logic signed [DW-1:0] s2_dy [NCORNER];
  logic [NCORNER-1:0]   s2_inr;
  logic [RW-1:0]        s2_rad;
  logic signed [VW-1:0] s2_vx, s2_vy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_decided <= b_decided;
    s2_hit     <= b_hit;
    s2_contact <= b_contact;
    for (int c = 0; c < NCORNER; c++) begin
      s2_dx[c] <= b_dx[c][DW-1:0];
      s2_dy[c] <= b_dy[c][DW-1:0];
    end
    s2_inr <= b_inr;
    s2_rad <= s1_rad;
    s2_vx  <= s1_vx;
    s2_vy  <= s1_vy;
  end

  // stage 3: squares and velocity products
  logic signed [2*DW-1:0]  c_dx2 [NCORNER];
  logic signed [2*DW-1:0]  c_dy2 [NCORNER];
  logic signed [VW+DW-1:0] c_vdx [NCORNER];
  logic signed [VW+DW-1:0] c_vdy [NCORNER];

  always_comb begin
    for (int c = 0; c < NCORNER; c++) begin
      c_dx2[c] = s2_dx[c] * s2_dx[c];
      c_dy2[c] = s2_dy[c] * s2_dy[c];
      c_vdx[c] = s2_vx * s2_dx[c];
      c_vdy[c] = s2_vy * s2_dy[c];
    end
  end

  logic                    s3_valid, s3_decided, s3_hit;
  contact_t                s3_contact;
  logic [SQW-1:0]          s3_dx2 [NCORNER];
  logic [SQW-1:0]          s3_dy2 [NCORNER];
  logic signed [VW+DW-1:0] s3_vdx [NCORNER];
  logic signed [VW+DW-1:0] s3_vdy [NCORNER];
  logic [NCORNER-1:0]      s3_inr, s3_sx, s3_sy;
  logic [2*RW-1:0]         s3_r2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
    s3_decided <= s2_decided;
    s3_hit     <= s2_hit;
    s3_contact <= s2_contact;
    for (int c = 0; c < NCORNER; c++) begin
      s3_dx2[c] <= c_dx2[c][SQW-1:0];
      s3_dy2[c] <= c_dy2[c][SQW-1:0];
      s3_vdx[c] <= c_vdx[c];
      s3_vdy[c] <= c_vdy[c];
      s3_sx[c]  <= s2_dx[c][DW-1];
      s3_sy[c]  <= s2_dy[c][DW-1];
    end
    s3_inr <= s2_inr;
    s3_r2  <= s2_rad * s2_rad;
  end

  // stage 4: corner tests, first corner wins
  logic [SW-1:0]          d_s [NCORNER];
  logic signed [DOTW-1:0] d_dot [NCORNER];
  logic [NCORNER-1:0]     d_ok;
  logic [CIDX_W-1:0]      d_sel;
  res_tag_t               d_tag;

  always_comb begin
    for (int c = 0; c < NCORNER; c++) begin
      d_s[c]   = SW'(s3_dx2[c]) + SW'(s3_dy2[c]);
      d_dot[c] = DOTW'(s3_vdx[c]) + DOTW'(s3_vdy[c]);
      d_ok[c]  = s3_inr[c] && (d_s[c] <= SW'(s3_r2))
                 && (d_dot[c][DOTW-1] || (d_dot[c] == '0));
    end
    d_sel = '0;
    for (int c = NCORNER - 1; c >= 0; c--) begin
      if (d_ok[c]) begin
        d_sel = CIDX_W'(c);
      end
    end
    d_tag.sx    = s3_sx[d_sel];
    d_tag.sy    = s3_sy[d_sel];
    d_tag.szero = (d_s[d_sel] == '0);
    priority if (s3_decided) begin
      d_tag.hit     = s3_hit;
      d_tag.contact = s3_contact;
    end else if (d_ok != '0) begin
      d_tag.hit     = 1'b1;
      d_tag.contact = CT_CORNER;
    end else begin
      d_tag.hit     = 1'b0;
      d_tag.contact = CT_NONE;
    end
  end

  logic           s4_valid;
  res_tag_t       s4_tag;
  logic [SW-1:0]  s4_s;
  logic [SQW-1:0] s4_ax2, s4_ay2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else begin
      s4_valid <= s3_valid;
    end
    s4_tag <= d_tag;
    s4_s   <= d_s[d_sel];
    s4_ax2 <= s3_dx2[d_sel];
    s4_ay2 <= s3_dy2[d_sel];
  end

  // normalization of the corner vector, one lane per component
  logic [MAG_W-1:0] mag_x, mag_y;

  crc_norm_pipe u_norm_x (
    .clk (clk),
    .s   (s4_s),
    .a2  (s4_ax2),
    .mag (mag_x)
  );

  crc_norm_pipe u_norm_y (
    .clk (clk),
    .s   (s4_s),
    .a2  (s4_ay2),
    .mag (mag_y)
  );

  // result tags follow the normalization stages
  logic [NORM_STEPS-1:0] tag_valid;
  res_tag_t              tag_pipe [0:NORM_STEPS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_valid <= '0;
    end else begin
      tag_valid <= {tag_valid[NORM_STEPS-2:0], s4_valid};
    end
    tag_pipe[0] <= s4_tag;
    for (int j = 1; j < NORM_STEPS; j++) begin
      tag_pipe[j] <= tag_pipe[j-1];
    end
  end

  // final normal selection
  res_tag_t             o_tag;
  logic signed [NW-1:0] o_mx, o_my, o_nx, o_ny;

  assign o_tag = tag_pipe[NORM_STEPS-1];
  assign o_mx  = $signed(NW'(mag_x));
  assign o_my  = $signed(NW'(mag_y));

  always_comb begin
    o_nx = '0;
    o_ny = '0;
    if (o_tag.hit) begin
      unique case (o_tag.contact)
        CT_LEFT:   o_nx = -ONE_Q14;
        CT_BOTTOM: o_ny = -ONE_Q14;
        CT_RIGHT:  o_nx = ONE_Q14;
        CT_TOP:    o_ny = ONE_Q14;
        CT_CORNER: begin
          if (!o_tag.szero) begin
            o_nx = o_tag.sx ? -o_mx : o_mx;
            o_ny = o_tag.sy ? -o_my : o_my;
          end
        end
        default: begin
          o_nx = '0;
          o_ny = '0;
        end
      endcase
    end
  end

  // output register, one cycle per result transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= tag_valid[NORM_STEPS-1];
    end
    hit      <= o_tag.hit;
    contact  <= o_tag.contact;
    normal_x <= o_nx;
    normal_y <= o_ny;
  end

  // checks
  `CRC_ASSERT_LAT(a_latency, start && !busy, LATENCY, done)
  `CRC_ASSERT_IMP(a_no_spurious, done, $past(start && !busy, LATENCY))
  `CRC_ASSERT_IMP(a_hit_contact, done, hit == (contact != CT_NONE))
  `CRC_ASSERT_IMP(a_miss_zero, done && !hit, normal_x == '0 && normal_y == '0)

endmodule

`default_nettype wire

[design/crc_norm_pipe.sv]
`default_nettype none

// pipelined search for round(16384 * a / sqrt(s)), one result bit per stage
module crc_norm_pipe import crc_pkg::*; (
  input  logic             clk,
  input  logic [SW-1:0]    s,
  input  logic [SQW-1:0]   a2,
  output logic [MAG_W-1:0] mag
);

  // u = 2m, p = u*u*s, q = u*s kept incrementally
  logic [PW-1:0]    p_acc [1:NORM_STEPS-1];
  logic [PW-1:0]    q_acc [1:NORM_STEPS-1];
  logic [PW-1:0]    s_acc [1:NORM_STEPS-1];
  logic [PW-1:0]    r_acc [1:NORM_STEPS-1];
  logic [MAG_W-1:0] m_acc [1:NORM_STEPS];

  for (genvar i = 0; i < NORM_STEPS; i++) begin : g_step
    localparam int K = NORM_STEPS - 1 - i;
    logic [PW-1:0]    p_in, q_in, s_in, r_in;
    logic [MAG_W-1:0] m_in;
    logic [PW-1:0]    cand_p, cand_q, err;
    logic             take;

    if (i == 0) begin : g_first
      assign p_in = '0;
      assign q_in = '0;
      assign s_in = PW'(s);
      assign r_in = PW'(a2) << R_SHIFT;
      assign m_in = '0;
    end else begin : g_next
      assign p_in = p_acc[i];
      assign q_in = q_acc[i];
      assign s_in = s_acc[i];
      assign r_in = r_acc[i];
      assign m_in = m_acc[i];
    end

    // try setting bit K of m: (2m-1)^2 * s against a^2 * 2^30
    assign cand_q = q_in + (s_in << (K + 1));
    assign cand_p = p_in + (q_in << (K + 2)) + (s_in << (2 * K + 2));
    assign err    = cand_p + s_in - (cand_q << 1);
    assign take   = (err <= r_in);

    always_ff @(posedge clk) begin
      m_acc[i+1] <= take ? (m_in | (MAG_W'(1) << K)) : m_in;
    end

    if (i < NORM_STEPS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        p_acc[i+1] <= take ? cand_p : p_in;
        q_acc[i+1] <= take ? cand_q : q_in;
        s_acc[i+1] <= s_in;
        r_acc[i+1] <= r_in;
      end
    end
  end

  assign mag = m_acc[NORM_STEPS];

endmodule

`default_nettype wire

[bench/collide_checker.sv]
`timescale 1ns / 100ps

module collide_checker import crc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic signed [15:0] ball_x,
  input  logic signed [15:0] ball_y,
  input  logic [11:0]        radius,
  input  logic signed [15:0] vel_x,
  input  logic signed [15:0] vel_y,
  input  logic signed [15:0] rect_x,
  input  logic signed [15:0] rect_y,
  input  logic [12:0]        rect_w,
  input  logic [12:0]        rect_h,
  input  logic               done,
  input  logic               hit,
  input  logic [2:0]         contact,
  input  logic signed [15:0] normal_x,
  input  logic signed [15:0] normal_y,
  output int                 errors,
  output int                 pending
);

  typedef struct packed {
    logic            hit;
    contact_t        contact;
    logic [15:0]     nx;
    logic [15:0]     ny;
  } bounce_t;

  bounce_t bounce_q[$];

  // rounded 16384 * a / sqrt(s) by bisection on the square
  function automatic longint unit_mag(longint a, longint s);
    longint lo, hi, mid, t, rhs;
    lo = 0;
    hi = 16384;
    rhs = (a * 32768) * (a * 32768);
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      t = 2 * mid - 1;
      if (t * t * s <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic bit touches(longint along, longint len, longint perp, longint rad);
    longint ap;
    ap = perp < 0 ? -perp : perp;
    return len > 0 && along >= 0 && along <= len && ap <= rad;
  endfunction

  function automatic bounce_t predict_bounce();
    longint cx, cy, rad, vx, vy, rx, ry, w, h, lf, rt, bt, tp, dx, dy, s, mx, my;
    longint kx[4], ky[4];
    bounce_t r;
    cx = 2 * longint'(ball_x);
    cy = 2 * longint'(ball_y);
    rad = 2 * longint'(radius);
    vx = vel_x;
    vy = vel_y;
    rx = 2 * longint'(rect_x);
    ry = 2 * longint'(rect_y);
    w = rect_w;
    h = rect_h;
    lf = rx - w; rt = rx + w; bt = ry - h; tp = ry + h;
    r = '{1'b0, CT_NONE, 16'd0, 16'd0};
    if (touches(tp - cy, 2 * h, cx - lf, rad)) begin
      if (vx > 0) r = '{1'b1, CT_LEFT, 16'hC000, 16'd0};
    end else if (touches(cx - lf, 2 * w, cy - bt, rad)) begin
      if (vy > 0) r = '{1'b1, CT_BOTTOM, 16'd0, 16'hC000};
    end else if (touches(cy - bt, 2 * h, cx - rt, rad)) begin
      if (vx < 0) r = '{1'b1, CT_RIGHT, 16'h4000, 16'd0};
    end else if (touches(rt - cx, 2 * w, cy - tp, rad)) begin
      if (vy < 0) r = '{1'b1, CT_TOP, 16'd0, 16'h4000};
    end else begin
      // corners: left-top, left-bottom, right-bottom, right-top
      kx = '{lf, lf, rt, rt};
      ky = '{tp, bt, bt, tp};
      for (int i = 0; i < 4; i++) begin
        dx = cx - kx[i];
        dy = cy - ky[i];
        s = dx * dx + dy * dy;
        if (s <= rad * rad && -(vx * dx) - vy * dy >= 0) begin
          r.hit = 1'b1;
          r.contact = CT_CORNER;
          if (s > 0) begin
            mx = unit_mag(dx < 0 ? -dx : dx, s);
            my = unit_mag(dy < 0 ? -dy : dy, s);
            r.nx = 16'(dx < 0 ? -mx : mx);
            r.ny = 16'(dy < 0 ? -my : my);
          end
          break;
        end
      end
    end
    return r;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    errors++;
  endtask

  assign pending = bounce_q.size();

  // predict on each input transfer, compare on each result strobe
  always @(posedge clk) begin
    bounce_t want;
    if (rst) begin
      errors = 0;
      bounce_q.delete();
    end else begin
      if (done) begin
        if (bounce_q.size() == 0) begin
          report("unexpected result", 1, 0);
        end else begin
          want = bounce_q.pop_front();
          if (hit !== want.hit) report("hit", hit, want.hit);
          if (contact !== want.contact) report("contact", contact, want.contact);
          if (normal_x !== want.nx)
            report("normal_x", normal_x, $signed(want.nx));
          if (normal_y !== want.ny)
            report("normal_y", normal_y, $signed(want.ny));
        end
      end
      if (start && !busy) bounce_q.insert(bounce_q.size(), predict_bounce());
    end
  end

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps

module testbench import crc_pkg::*;;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done, hit;
  logic [2:0] contact;
  logic signed [15:0] normal_x, normal_y;
  logic signed [15:0] ball_x = '0, ball_y = '0, vel_x = '0, vel_y = '0;
  logic signed [15:0] rect_x = '0, rect_y = '0;
  logic [11:0] radius = '0;
  logic [12:0] rect_w = '0, rect_h = '0;
  int errors, pending;
  int idle_pct = 0;
  int stall_cycles = 0;
  localparam int STALL_LIMIT = 2000;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  circle_rect_collide_reflect uut (.*);

  collide_checker chk (.*);

  // watchdog: cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // one query transfer, with optional idle cycles before it
  task automatic send(logic signed [15:0] bx, by, vx, vy, rx, ry,
                      logic [11:0] r, logic [12:0] w, h);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    ball_x <= bx; ball_y <= by; radius <= r;
    vel_x <= vx; vel_y <= vy;
    rect_x <= rx; rect_y <= ry; rect_w <= w; rect_h <= h;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // random query placed near the rectangle so edges and corners get touched
  task automatic send_near();
    int rx, ry, w, h, r, bx, by;
    rx = $urandom_range(4000) - 2000;
    ry = $urandom_range(4000) - 2000;
    w = ($urandom_range(9) == 0) ? 0 : $urandom_range(8191);
    h = ($urandom_range(9) == 0) ? 0 : $urandom_range(8191);
    r = $urandom_range(4095);
    bx = rx + $signed($urandom_range(2 * (w / 2 + r + 40))) - (w / 2 + r + 40);
    by = ry + $signed($urandom_range(2 * (h / 2 + r + 40))) - (h / 2 + r + 40);
    send(16'(bx), 16'(by), 16'($urandom), 16'($urandom), 16'(rx), 16'(ry),
         12'(r), 13'(w), 13'(h));
  endtask

  initial begin
    int phases[4] = '{0, 50, 0, 12};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // edges of rect 20x10 at origin (units Q12.4), moving in and out
    send(-170, 0, 16, 0, 0, 0, 20, 320, 160);    // left, heading in
    send(-170, 0, -16, 0, 0, 0, 20, 320, 160);   // left, heading out
    send(0, -90, 0, 16, 0, 0, 20, 320, 160);     // bottom
    send(170, 0, -16, 0, 0, 0, 20, 320, 160);    // right
    send(0, 90, 0, -16, 0, 0, 20, 320, 160);     // top
    send(0, 90, 0, 16, 0, 0, 20, 320, 160);      // top, heading out
    send(-165, 85, 16, -16, 0, 0, 20, 320, 160); // corner left-top
    send(-165, -85, 16, 16, 0, 0, 20, 320, 160);
    send(165, -85, -16, 16, 0, 0, 20, 320, 160);
    send(165, 85, -16, -16, 0, 0, 20, 320, 160);
    send(-165, 85, -16, 16, 0, 0, 20, 320, 160); // corner, moving away
    send(-160, 80, 0, 0, 0, 0, 0, 320, 160);     // center on corner
    send(5, 0, 16, 0, 0, 0, 10, 0, 0);           // zero-size rect
    send(0, 0, 0, 0, 0, 0, 4095, 0, 100);        // zero width
    send(-32768, -32768, -32768, -32768, 32767, 32767, 4095, 8191, 8191);
    send(32767, 32767, 32767, 32767, -32768, -32768, 4095, 8191, 8191);
    send(-32768, 32767, 32767, -32768, -32768, 32767, 0, 8191, 0);
    send(0, 0, 0, 0, 0, 0, 0, 0, 0);
    send(-160, 0, 1, 0, 0, 0, 0, 320, 160);      // on edge, radius zero

    // random phases with varied sender idling
    for (int p = 0; p < 4; p++) begin
      idle_pct = phases[p];
      for (int i = 0; i < 225; i++) begin
        if ($urandom_range(4) == 0)
          send(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
               16'($urandom), 16'($urandom), 12'($urandom), 13'($urandom),
               13'($urandom));
        else send_near();
      end
    end
    start <= 1'b0;
    @(posedge clk);

    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

[sim.f]
+incdir+design
design/crc_pkg.sv
design/crc_norm_pipe.sv
design/circle_rect_collide_reflect.sv
bench/collide_checker.sv
bench/testbench.sv
